/* design/lpse_pkg.sv */
package lpse_pkg;

  localparam int unsigned LEDS_DEF = 16;
  localparam int unsigned MAX_LEVEL = 255;

  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_PULSE = 2'd1;
  localparam logic [1:0] MODE_STREAK = 2'd2;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_RED = 3'd1;
  localparam logic [2:0] REG_GREEN = 3'd2;
  localparam logic [2:0] REG_BLUE = 3'd3;
  localparam logic [2:0] REG_PERIOD = 3'd4;
  localparam logic [2:0] REG_REVERSE = 3'd5;
  localparam logic [2:0] REG_BRIGHT = 3'd6;

  localparam logic [15:0] PERIOD_RST = 16'd100;
  localparam logic [7:0] BRIGHT_RST = 8'((MAX_LEVEL < 255) ? MAX_LEVEL : 255);
  localparam logic [7:0] MAX_LEVEL_V = 8'(MAX_LEVEL);
  localparam logic [31:0] REFRESH_MS = 32'd16;
  localparam logic [15:0] STREAK_LEVEL = 16'd200;
  localparam logic [15:0] ROUND_BIAS = 16'd127;
  localparam logic [4:0] STEP_MIN = 5'd2;
  localparam int unsigned STEP_FIRST = 3;

  // Largest period for which the pulse step reaches 3, 4, ... 20.
  localparam logic [15:0] STEP_LIMIT [18] = '{
    16'd3413, 16'd2560, 16'd2048, 16'd1706, 16'd1462, 16'd1280,
    16'd1137, 16'd1024, 16'd930, 16'd853, 16'd787, 16'd731,
    16'd682, 16'd640, 16'd602, 16'd568, 16'd538, 16'd512
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FACTOR,
    ST_SCALE,
    ST_DIM,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
    logic factor;
    logic scale;
    logic dim;
    logic load;
  } lpse_cmd_t;

  typedef struct packed {
    logic go;
    logic out_free;
    logic emit_last;
  } lpse_sts_t;

  function automatic logic [4:0] phase_step(input logic [15:0] period);
    logic [4:0] s;
    s = STEP_MIN;
    for (int unsigned i = 0; i < 18; i++) begin
      if (period <= STEP_LIMIT[i]) begin
        s = 5'(i + STEP_FIRST);
      end
    end
    return s;
  endfunction

  // Exact v / 255 for v below 65280.
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [7:0] q;
    logic [8:0] r;
    q = v[15:8];
    r = {1'b0, v[7:0]} + {1'b0, q};
    if (r >= 9'd255) begin
      q = q + 8'd1;
    end
    return q;
  endfunction

  // Exact v / 511 for v below 130560.
  function automatic logic [7:0] div511(input logic [16:0] v);
    logic [7:0] q;
    logic [9:0] r;
    q = v[16:9];
    r = {1'b0, v[8:0]} + {2'b0, q};
    if (r >= 10'd511) begin
      q = q + 8'd1;
    end
    return q;
  endfunction

endpackage

/* design/lpse_ifs.sv */
interface lpse_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] current_time;
  modport source(output valid, output current_time, input ready);
  modport sink(input valid, input current_time, output ready);
endinterface

interface lpse_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] pixel_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last;
  logic       show_frame;
  modport source(output valid, output pixel_index, output red, output green,
                 output blue, output last, output show_frame, input ready);
  modport sink(input valid, input pixel_index, input red, input green,
               input blue, input last, input show_frame, output ready);
endinterface

interface lpse_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [15:0] data;
  modport source(output valid, output reg_index, output data, input ready);
  modport sink(input valid, input reg_index, input data, output ready);
endinterface

/* design/lpse_ctrl.sv */
module lpse_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lpse_pkg::lpse_sts_t sts,
  output lpse_pkg::lpse_cmd_t cmd
);

  lpse_pkg::state_t state_r;
  lpse_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpse_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpse_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = lpse_pkg::ST_CHECK;
        end
      end
      lpse_pkg::ST_CHECK: begin
        state_nxt = sts.go ? lpse_pkg::ST_FACTOR : lpse_pkg::ST_IDLE;
      end
      lpse_pkg::ST_FACTOR: state_nxt = lpse_pkg::ST_SCALE;
      lpse_pkg::ST_SCALE: state_nxt = lpse_pkg::ST_DIM;
      lpse_pkg::ST_DIM: state_nxt = lpse_pkg::ST_EMIT;
      lpse_pkg::ST_EMIT: begin
        if (sts.out_free && sts.emit_last) begin
          state_nxt = lpse_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lpse_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      lpse_pkg::ST_IDLE: begin
        in_ready = rst_n;
        cmd.capture = in_valid && rst_n;
      end
      lpse_pkg::ST_CHECK: cmd.commit = sts.go;
      lpse_pkg::ST_FACTOR: cmd.factor = 1'b1;
      lpse_pkg::ST_SCALE: cmd.scale = 1'b1;
      lpse_pkg::ST_DIM: cmd.dim = 1'b1;
      lpse_pkg::ST_EMIT: cmd.load = sts.out_free;
      default: cmd = '0;
    endcase
  end

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in work");

  a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lpse_pkg::ST_EMIT && !sts.out_free) |=> state_r == lpse_pkg::ST_EMIT)
    else $error("emission left while output was stalled");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && sts.emit_last) |=> in_ready)
    else $error("not ready after final pixel write");

endmodule

/* design/lpse_datapath.sv */
module lpse_datapath #(
  parameter int unsigned LEDS_PER_SECTION = lpse_pkg::LEDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [31:0]         in_time,
  input  lpse_pkg::lpse_cmd_t cmd,
  output lpse_pkg::lpse_sts_t sts,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [5:0]          out_pixel_index,
  output logic [7:0]          out_red,
  output logic [7:0]          out_green,
  output logic [7:0]          out_blue,
  output logic                out_last,
  output logic                out_show_frame
);

  localparam int unsigned N = LEDS_PER_SECTION;
  localparam int unsigned TRAIL = (N / 5 < 1) ? 1 : N / 5;
  localparam int unsigned PIX_W = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned SUM_W = PIX_W + 2;
  localparam logic [PIX_W-1:0] LAST_PIX = PIX_W'(N - 1);
  localparam logic [PIX_W-1:0] TRAIL_M1 = PIX_W'(TRAIL - 1);
  localparam logic [SUM_W-1:0] N_S = SUM_W'(N);
  localparam logic [SUM_W-1:0] FWD_OFF = SUM_W'(N + 1 - TRAIL);
  localparam logic [SUM_W-1:0] REV_OFF = SUM_W'(TRAIL - 1);

  logic [1:0]            mode_r;
  logic [2:0][7:0]       base_r;
  logic [15:0]           period_r;
  logic                  rev_r;
  logic [7:0]            bright_r;
  logic [9:0]            phase_r;
  logic [PIX_W-1:0]      head_r;
  logic [PIX_W-1:0]      tail_r;
  logic                  tail_vld_r;
  logic [31:0]           upd_time_r;
  logic [31:0]           show_time_r;
  logic [31:0]           time_r;
  logic                  show_ok_r;
  logic [7:0]            f_r;
  logic [2:0][7:0]       sc_r;
  logic [2:0][7:0]       col_r;
  logic [PIX_W-1:0]      cnt_r;
  logic [PIX_W-1:0]      pix_r;
  logic                  clr_pend_r;
  logic                  out_valid_r;
  logic [5:0]            out_pix_r;
  logic [2:0][7:0]       out_col_r;
  logic                  out_last_r;
  logic                  out_show_r;

  logic                  is_pulse;
  logic                  is_streak;
  logic                  go;
  logic                  out_free;
  logic                  emit_last;
  logic [PIX_W-1:0]      total_m1;
  logic [PIX_W-1:0]      pix_inc;
  logic [PIX_W-1:0]      pix_dec;
  logic [PIX_W-1:0]      pix_nxt;
  logic [PIX_W-1:0]      head_nxt;
  logic [PIX_W-1:0]      tail_nxt;
  logic [SUM_W-1:0]      tail_sum;
  logic [8:0]            tri_x;
  logic [16:0]           tri_v;
  logic [7:0]            f_nxt;
  logic [2:0][7:0]       sc_nxt;
  logic [2:0][7:0]       col_nxt;
  logic [15:0]           prod;
  logic [15:0]           dprod;

  assign is_pulse = (mode_r == lpse_pkg::MODE_PULSE);
  assign is_streak = (mode_r == lpse_pkg::MODE_STREAK);
  assign go = (is_pulse || is_streak) && ((time_r - upd_time_r) >= {16'd0, period_r});
  assign out_free = !out_valid_r || out_ready;
  assign total_m1 = is_pulse ? LAST_PIX : TRAIL_M1;
  assign emit_last = !clr_pend_r && (cnt_r == total_m1);

  assign sts.go = go;
  assign sts.out_free = out_free;
  assign sts.emit_last = emit_last;

  always_comb begin
    pix_inc = (pix_r == LAST_PIX) ? '0 : pix_r + PIX_W'(1);
    pix_dec = (pix_r == '0) ? LAST_PIX : pix_r - PIX_W'(1);
    pix_nxt = (is_pulse || rev_r) ? pix_inc : pix_dec;
    if (rev_r) begin
      head_nxt = (head_r == '0) ? LAST_PIX : head_r - PIX_W'(1);
      tail_sum = {2'b0, head_r} + REV_OFF;
    end else begin
      head_nxt = (head_r == LAST_PIX) ? '0 : head_r + PIX_W'(1);
      tail_sum = {2'b0, head_r} + FWD_OFF;
    end
    if (tail_sum >= N_S) begin
      tail_sum = tail_sum - N_S;
    end
    tail_nxt = tail_sum[PIX_W-1:0];
  end

  always_comb begin
    tri_x = phase_r[9] ? ~phase_r[8:0] : phase_r[8:0];
    tri_v = {tri_x, 8'd0} - {8'd0, tri_x};
    f_nxt = lpse_pkg::div511(tri_v);
    prod = '0;
    dprod = '0;
    for (int unsigned c = 0; c < 3; c++) begin
      if (is_pulse) begin
        prod = {8'd0, base_r[c]} * {8'd0, f_r};
        sc_nxt[c] = lpse_pkg::div255(prod);
      end else begin
        prod = {8'd0, base_r[c]} * lpse_pkg::STREAK_LEVEL;
        sc_nxt[c] = prod[15:8];
      end
      dprod = {8'd0, sc_r[c]} * {8'd0, bright_r} + lpse_pkg::ROUND_BIAS;
      col_nxt[c] = lpse_pkg::div255(dprod);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= lpse_pkg::MODE_OFF;
      base_r <= '0;
      period_r <= lpse_pkg::PERIOD_RST;
      rev_r <= 1'b0;
      bright_r <= lpse_pkg::BRIGHT_RST;
      phase_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      tail_vld_r <= 1'b0;
      upd_time_r <= '0;
      show_time_r <= '0;
      cnt_r <= '0;
      pix_r <= '0;
      clr_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          lpse_pkg::REG_MODE: begin
            mode_r <= cfg_data[1:0];
            phase_r <= '0;
            head_r <= rev_r ? LAST_PIX : '0;
            tail_r <= '0;
            tail_vld_r <= 1'b0;
          end
          lpse_pkg::REG_RED: base_r[0] <= cfg_data[7:0];
          lpse_pkg::REG_GREEN: base_r[1] <= cfg_data[7:0];
          lpse_pkg::REG_BLUE: base_r[2] <= cfg_data[7:0];
          lpse_pkg::REG_PERIOD: period_r <= cfg_data;
          lpse_pkg::REG_REVERSE: rev_r <= cfg_data[0];
          lpse_pkg::REG_BRIGHT: begin
            bright_r <= (cfg_data[7:0] > lpse_pkg::MAX_LEVEL_V) ?
                        lpse_pkg::MAX_LEVEL_V : cfg_data[7:0];
          end
          default: ;
        endcase
      end
      if (cmd.commit) begin
        upd_time_r <= time_r;
        if (is_pulse) begin
          phase_r <= phase_r + {5'd0, lpse_pkg::phase_step(period_r)};
        end
        cnt_r <= '0;
        pix_r <= is_pulse ? '0 : head_r;
        clr_pend_r <= is_streak && tail_vld_r;
      end
      if (cmd.load) begin
        if (clr_pend_r) begin
          clr_pend_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + PIX_W'(1);
          pix_r <= pix_nxt;
        end
        if (emit_last) begin
          if (is_streak) begin
            head_r <= head_nxt;
            tail_r <= tail_nxt;
            tail_vld_r <= 1'b1;
          end
          if (show_ok_r) begin
            show_time_r <= time_r;
          end
        end
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      time_r <= in_time;
    end
    if (cmd.commit) begin
      show_ok_r <= (time_r - show_time_r) >= lpse_pkg::REFRESH_MS;
    end
    if (cmd.factor) begin
      f_r <= f_nxt;
    end
    if (cmd.scale) begin
      sc_r <= sc_nxt;
    end
    if (cmd.dim) begin
      col_r <= col_nxt;
    end
    if (cmd.load) begin
      out_pix_r <= clr_pend_r ? 6'(tail_r) : 6'(pix_r);
      out_col_r <= clr_pend_r ? '0 : col_r;
      out_last_r <= emit_last;
      out_show_r <= emit_last && show_ok_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel_index = out_pix_r;
  assign out_red = out_col_r[0];
  assign out_green = out_col_r[1];
  assign out_blue = out_col_r[2];
  assign out_last = out_last_r;
  assign out_show_frame = out_show_r;

  a_show_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_show_r) |-> out_last_r)
    else $error("refresh flagged on a write that is not the final one");

  a_tail_armed: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && emit_last && is_streak && !cfg_valid) |=> tail_vld_r)
    else $error("tail pixel not armed after a streak update");

  a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
    clr_pend_r |-> (cnt_r == '0))
    else $error("tail clear pending after trail writes started");

endmodule

/* design/led_pulse_streak_effect_core.sv */
// Flow: a taken request is checked in CHECK; an update then passes FACTOR, SCALE and
// DIM into EMIT, which loads the output register with one write per cycle while the
// output is free. A request that causes no update returns to IDLE from CHECK; one that
// updates issues K writes, K being LEDS_PER_SECTION in pulse mode or the trail length
// plus one tail clear when a tail is pending in streak mode, before IDLE takes another.
// Reset: rst_n is synchronous and active low; control and configuration registers take
// their default values and the effect state restarts. There is no clearing pass.
module led_pulse_streak_effect_core #(
  parameter int unsigned LEDS_PER_SECTION = lpse_pkg::LEDS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  lpse_in_if.sink    in_ch,
  lpse_out_if.source out_ch,
  lpse_cfg_if.sink   cfg_ch
);

  lpse_pkg::lpse_cmd_t cmd;
  lpse_pkg::lpse_sts_t sts;
  logic                cfg_write;

  assign cfg_ch.ready = rst_n;
  assign cfg_write = cfg_ch.valid;

  lpse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lpse_datapath #(
    .LEDS_PER_SECTION (LEDS_PER_SECTION)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_write),
    .cfg_index       (cfg_ch.reg_index),
    .cfg_data        (cfg_ch.data),
    .in_time         (in_ch.current_time),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_pixel_index (out_ch.pixel_index),
    .out_red         (out_ch.red),
    .out_green       (out_ch.green),
    .out_blue        (out_ch.blue),
    .out_last        (out_ch.last),
    .out_show_frame  (out_ch.show_frame)
  );

endmodule
